// ===== rtl/core/stbs_pkg.sv =====
`default_nettype none

package stbs_pkg;

  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int DATA_W      = 32;
  localparam int INDEX_W     = 10;
  localparam int OUT_TDATA_W = 16;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_SEARCH = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CMP  = 3'b010,
    S_DONE = 3'b100
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/sorted_table_binary_search_core.sv =====
// clear and append give no result and keep the core in idle, ready for the next word
// search: the word is taken in idle, each probe runs in the compare state, and the done
// state loads the result word; at most 11 probes for 1024 entries, none for an empty table
// one probe per cycle, set by the single registered read port of the table memory
// a finished search waits while the previous result word is held, blocking the input
// reset (synchronous, active low) empties the table; entry contents stay undefined
`default_nettype none

module sorted_table_binary_search_core
  import stbs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [DATA_W-1:0]      in_tdata,   // value
  input  wire logic [1:0]             in_tuser,   // cmd
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic      [OUT_TDATA_W-1:0] out_tdata,  // index, zero padded
  output logic                        out_tuser   // found
);

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [CNT_W-1:0]    lo_r, lo_nxt;
  logic [CNT_W-1:0]    hi_p1_r, hi_p1_nxt;
  logic [ADDR_W-1:0]   mid_r, mid_nxt;
  logic [DATA_W-1:0]   key_r, key_nxt;
  logic                res_found_r, res_found_nxt;
  logic [INDEX_W-1:0]  res_index_r, res_index_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                out_found_r, out_found_nxt;
  logic [INDEX_W-1:0]  out_index_r, out_index_nxt;

  logic                ram_we;
  logic [ADDR_W-1:0]   ram_raddr;
  logic [DATA_W-1:0]   ram_rdata;

  logic                in_acc;
  logic [CNT_W-1:0]    mid_ext;
  logic [CNT_W-1:0]    mid_p1;
  logic [CNT_W:0]      sum_dn;
  logic [CNT_W:0]      sum_up;
  logic                key_eq;
  logic                key_lt;

  stbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count_r[ADDR_W-1:0]),
    .wdata (in_tdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign mid_ext = CNT_W'(mid_r);
  assign mid_p1  = mid_ext + CNT_W'(1);
  // next probe for the lower and upper half, both worked out ahead of the compare
  assign sum_dn  = {1'b0, lo_r} + {1'b0, mid_ext} - (CNT_W+1)'(1);
  assign sum_up  = {1'b0, mid_ext} + {1'b0, hi_p1_r};
  assign key_eq  = ($signed(key_r) == $signed(ram_rdata));
  assign key_lt  = ($signed(key_r) < $signed(ram_rdata));

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    lo_nxt        = lo_r;
    hi_p1_nxt     = hi_p1_r;
    mid_nxt       = mid_r;
    key_nxt       = key_r;
    res_found_nxt = res_found_r;
    res_index_nxt = res_index_r;
    out_valid_nxt = out_valid_r;
    out_found_nxt = out_found_r;
    out_index_nxt = out_index_r;
    ram_we        = 1'b0;
    ram_raddr     = mid_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_tuser)
            CMD_CLEAR: begin
              count_nxt = '0;
            end
            CMD_APPEND: begin
              if (count_r < CNT_W'(TABLE_DEPTH)) begin
                ram_we    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            CMD_SEARCH: begin
              key_nxt   = in_tdata;
              lo_nxt    = '0;
              hi_p1_nxt = count_r;
              if (count_r == '0) begin
                res_found_nxt = 1'b0;
                res_index_nxt = '0;
                state_nxt     = S_DONE;
              end else begin
                mid_nxt   = ADDR_W'((count_r - CNT_W'(1)) >> 1);
                ram_raddr = mid_nxt;
                state_nxt = S_CMP;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_CMP: begin
        if (key_eq) begin
          res_found_nxt = 1'b1;
          res_index_nxt = INDEX_W'(mid_r);
          state_nxt     = S_DONE;
        end else if (key_lt) begin
          hi_p1_nxt = mid_ext;
          if (lo_r >= mid_ext) begin
            res_found_nxt = 1'b0;
            res_index_nxt = '0;
            state_nxt     = S_DONE;
          end else begin
            mid_nxt   = ADDR_W'(sum_dn >> 1);
            ram_raddr = mid_nxt;
          end
        end else begin
          lo_nxt = mid_p1;
          if (mid_p1 >= hi_p1_r) begin
            res_found_nxt = 1'b0;
            res_index_nxt = '0;
            state_nxt     = S_DONE;
          end else begin
            mid_nxt   = ADDR_W'(sum_up >> 1);
            ram_raddr = mid_nxt;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_found_nxt = res_found_r;
          out_index_nxt = res_index_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r        <= lo_nxt;
    hi_p1_r     <= hi_p1_nxt;
    mid_r       <= mid_nxt;
    key_r       <= key_nxt;
    res_found_r <= res_found_nxt;
    res_index_r <= res_index_nxt;
    out_found_r <= out_found_nxt;
    out_index_r <= out_index_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = OUT_TDATA_W'(out_index_r);

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> (state_r == S_IDLE))
    else $error("table write outside idle");

  a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (lo_r <= mid_ext) && (mid_ext < hi_p1_r) && (hi_p1_r <= count_r))
    else $error("probe outside search range");

  a_miss_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_index_r == '0))
    else $error("miss with non-zero index");

endmodule

`default_nettype wire

// ===== rtl/core/stbs_ram.sv =====
`default_nettype none

module stbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== verif/binary_search_checker.sv =====
module binary_search_checker
  import stbs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [DATA_W-1:0]      in_tdata,   // value
  input  logic [1:0]             in_tuser,   // cmd
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,  // index, zero padded
  input  logic                   out_tuser,  // found
  output int                     fail_count,
  output int                     pending_results,
  output int                     results_checked,
  output int                     hit_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic               found;
    logic [INDEX_W-1:0] index;
  } lookup_t;

  logic signed [DATA_W-1:0] entries [TABLE_DEPTH];
  int                       entry_count;
  lookup_t                  expected_lookups [$];

  function automatic lookup_t lookup_key(input logic signed [DATA_W-1:0] key);
    int                       lo;
    int                       hi;
    int                       mid;
    logic signed [DATA_W-1:0] ent;
    lookup_t                  res;
    res = '0;
    lo = 0;
    hi = entry_count - 1;
    while (lo <= hi) begin
      mid = (lo + hi) / 2;
      ent = entries[mid];
      if (ent == key) begin
        res.found = 1'b1;
        res.index = mid[INDEX_W-1:0];
        return res;
      end else if (key < ent) begin
        hi = mid - 1;
      end else begin
        lo = mid + 1;
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    lookup_t want;
    if (!rst_n) begin
      entry_count = 0;
      expected_lookups.delete();
      fail_count = 0;
      results_checked = 0;
      hit_count = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_lookups.size() == 0) begin
          $error("unexpected result word: found %0d index %0d", out_tuser,
                 out_tdata[INDEX_W-1:0]);
          fail_count++;
        end else begin
          want = expected_lookups.pop_front();
          results_checked++;
          if (want.found) hit_count++;
          if (out_tuser !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_tuser);
            fail_count++;
          end
          if (out_tdata[INDEX_W-1:0] !== want.index) begin
            $error("index: expected %0d, got %0d", want.index, out_tdata[INDEX_W-1:0]);
            fail_count++;
          end
          if (out_tdata[OUT_TDATA_W-1:INDEX_W] !== '0) begin
            $error("index padding: expected 0, got %0h", out_tdata[OUT_TDATA_W-1:INDEX_W]);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          CMD_CLEAR: begin
            entry_count = 0;
          end
          CMD_APPEND: begin
            if (entry_count < TABLE_DEPTH) begin
              entries[entry_count] = in_tdata;
              entry_count++;
            end
          end
          CMD_SEARCH: begin
            expected_lookups.push_back(lookup_key(in_tdata));
          end
          default: ;
        endcase
      end
    end
    pending_results <= expected_lookups.size();
  end

endmodule

// ===== verif/sorted_table_binary_search_core_tb.sv =====
module sorted_table_binary_search_core_tb;
  import stbs_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CLK_PERIOD  = 8;
  localparam int          RESET_LEN   = 11;
  localparam int          IDLE_LIMIT  = 2000;
  localparam int          TAIL_CYCLES = 20;
  localparam int          RANDOM_WORDS = 150;
  localparam int          LARGE_TABLE = 560;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [31:0] VALUE_MIN   = 32'h8000_0000;
  localparam logic [31:0] VALUE_MAX   = 32'h7fff_ffff;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [DATA_W-1:0]      in_tdata = '0;  // value
  logic [1:0]             in_tuser = '0;  // cmd
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;      // index, zero padded
  logic                   out_tuser;      // found

  int fail_count;
  int pending_results;
  int results_checked;
  int hit_count;

  int          words_sent;
  int          searches_sent;
  int          idle_cycles = 0;
  bit          steady;
  logic [31:0] table_mirror [$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  sorted_table_binary_search_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  binary_search_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .fail_count      (fail_count),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .hit_count       (hit_count)
  );

  function automatic int idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic logic [31:0] pick_key();
    int r;
    int n;
    n = table_mirror.size();
    r = $urandom_range(0, 99);
    if (n != 0 && r < 55) return table_mirror[$urandom_range(0, n - 1)];
    if (n != 0 && r < 75)
      return table_mirror[$urandom_range(0, n - 1)] + ($urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff);
    if (r < 85) return $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
    return $urandom;
  endfunction

  task automatic send_word(input logic [1:0] cmd, input logic [31:0] value);
    int gap;
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    case (cmd)
      CMD_CLEAR:  table_mirror.delete();
      CMD_APPEND: if (table_mirror.size() < TABLE_DEPTH) table_mirror.push_back(value);
      CMD_SEARCH: searches_sent++;
      default: ;
    endcase
    if (cmd != CMD_UNUSED) words_sent++;
    gap = idle_gap();
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
  endtask

  task automatic load_sorted(input int n, input longint base, input int unsigned spread);
    longint cur;
    cur = base;
    send_word(CMD_CLEAR, $urandom);
    for (int i = 0; i < n; i++) begin
      cur = cur + $urandom_range(0, spread);
      if (cur > 64'sd2147483647) cur = 64'sd2147483647;
      send_word(CMD_APPEND, cur[31:0]);
    end
  endtask

  task automatic random_sequence();
    int          r;
    int          n;
    int          b;
    int unsigned spread;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      r = $urandom_range(0, 99);
      n = (r < 8) ? 0 : (r < 92) ? $urandom_range(1, 24) : $urandom_range(60, 200);
      r = $urandom_range(0, 2);
      spread = (r == 0) ? 3 : (r == 1) ? (1 << 20) : (1 << 28);
      b = $urandom;
      load_sorted(n, b, spread);
      n = $urandom_range(1, 8);
      repeat (n) send_word(CMD_SEARCH, pick_key());
    end else begin
      n = $urandom_range(4, 20);
      repeat (n) begin
        r = $urandom_range(0, 99);
        if (r < 50) send_word(CMD_APPEND, $urandom);
        else if (r < 85) send_word(CMD_SEARCH, pick_key());
        else if (r < 90) send_word(CMD_CLEAR, $urandom);
        else send_word(CMD_UNUSED, $urandom);
      end
    end
  endtask

  // out side: random stalls, mostly short, some long, with long ready stretches
  initial begin
    int r;
    @(posedge clk);
    forever begin
      r = $urandom_range(0, 99);
      out_tready <= 1'b1;
      repeat (r < 70 ? $urandom_range(1, 6) : $urandom_range(20, 60)) @(posedge clk);
      r = $urandom_range(0, 99);
      out_tready <= 1'b0;
      repeat (r < 75 ? $urandom_range(1, 3) : $urandom_range(8, 40)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    words_sent = 0;
    searches_sent = 0;
    steady = 1'b0;
    repeat (RESET_LEN) @(posedge clk);
    rst_n <= 1'b1;

    // empty table, unused command
    send_word(CMD_SEARCH, 32'd0);
    send_word(CMD_SEARCH, VALUE_MIN);
    send_word(CMD_UNUSED, 32'hdead_beef);
    // extremes and duplicates
    send_word(CMD_APPEND, VALUE_MIN);
    send_word(CMD_APPEND, 32'hffff_ffff);
    send_word(CMD_APPEND, 32'd0);
    send_word(CMD_APPEND, 32'd1);
    send_word(CMD_APPEND, 32'd5);
    send_word(CMD_APPEND, 32'd5);
    send_word(CMD_APPEND, 32'd5);
    send_word(CMD_APPEND, VALUE_MAX);
    send_word(CMD_SEARCH, VALUE_MIN);
    send_word(CMD_SEARCH, VALUE_MAX);
    send_word(CMD_SEARCH, 32'd0);
    send_word(CMD_SEARCH, 32'd5);
    send_word(CMD_SEARCH, 32'd3);
    send_word(CMD_SEARCH, 32'hffff_fffe);
    send_word(CMD_SEARCH, 32'hffff_ffff);
    // out of order entry
    send_word(CMD_APPEND, 32'hffff_fff9);
    send_word(CMD_SEARCH, 32'hffff_fff9);
    // search after clear
    send_word(CMD_CLEAR, 32'd0);
    send_word(CMD_SEARCH, 32'd0);
    send_word(CMD_APPEND, 32'd42);
    send_word(CMD_SEARCH, 32'd42);
    send_word(CMD_SEARCH, 32'd41);
    wait_for_results();

    while (words_sent < RANDOM_WORDS) begin
      steady = ($urandom_range(0, 3) == 0);
      random_sequence();
      if ($urandom_range(0, 7) == 0) wait_for_results();
    end
    steady = 1'b0;
    wait_for_results();

    // large table, all index bits exercised
    load_sorted(LARGE_TABLE, -64'sd2147483648 + $urandom_range(0, 1 << 30), 1 << 21);
    send_word(CMD_SEARCH, table_mirror[LARGE_TABLE - 1]);
    send_word(CMD_SEARCH, table_mirror[0]);
    send_word(CMD_SEARCH, table_mirror[373]);
    send_word(CMD_SEARCH, table_mirror[186]);
    send_word(CMD_SEARCH, table_mirror[512]);
    repeat (25) send_word(CMD_SEARCH, pick_key());
    send_word(CMD_CLEAR, $urandom);
    send_word(CMD_SEARCH, pick_key());

    wait_for_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("sent %0d words including %0d searches; %0d results compared, %0d of them hits",
             words_sent, searches_sent, results_checked, hit_count);
    $display("covered empty, duplicate, unordered and large tables plus unused commands");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
